FILE: rtl/core/differential_drive_speed_loop_assert.svh
// ----------------------------------------------------------------------------
// Differential drive speed loop assertion macros
// Concurrent property macros used by the speed loop top level.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_SPEED_LOOP_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_SPEED_LOOP_ASSERT_SVH

// same-cycle implication under asynchronous active-low reset
`define DDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define DDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dds_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive speed loop package
// Widths, register codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package dds_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MUL_W      = 17;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int DIFF_W     = 15;
	localparam int TGT_W      = 16;
	localparam int ACCUM_W    = 24;
	localparam int RERR_W     = 14;
	localparam int PWM_W      = 16;
	localparam int SPEED_W    = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATE_KP   = 3'd0,
		CFG_RATE_KD   = 3'd1,
		CFG_WHEEL_KP  = 3'd2,
		CFG_WHEEL_KI  = 3'd3,
		CFG_WHEEL_KFF = 3'd4,
		CFG_RAMP_STEP = 3'd5,
		CFG_PWM_LIMIT = 3'd6
	} dds_cfg_idx_t;

	typedef struct packed {
		logic [15:0] rate_kp;
		logic [15:0] rate_kd;
		logic [15:0] wheel_kp;
		logic [15:0] wheel_ki;
		logic [15:0] wheel_kff;
		logic [7:0]  ramp_step;
		logic [14:0] pwm_limit;
	} dds_cfg_t;

	typedef enum logic [2:0] {
		MUL_NONE     = 3'd0,
		MUL_RATE_KP  = 3'd1,
		MUL_RATE_KD  = 3'd2,
		MUL_WHEEL_KP = 3'd3,
		MUL_WHEEL_KI = 3'd4,
		MUL_WHEEL_FF = 3'd5
	} dds_mul_t;

	typedef enum logic [1:0] {
		ACC_HOLD  = 2'd0,
		ACC_LOAD  = 2'd1,
		ACC_ADD   = 2'd2,
		ACC_ACCUM = 2'd3
	} dds_acc_t;

	typedef struct packed {
		logic     capture;
		logic     rate_step;
		dds_mul_t mul_sel;
		dds_acc_t acc_op;
		logic     diff_load;
		logic     wheel_err;
		logic     accum_load;
		logic     pwm_load;
		logic     side;
		logic     out_load;
	} dds_cmd_t;

	typedef struct packed {
		logic out_free;
	} dds_sts_t;

endpackage

FILE: rtl/core/dds_in_if.sv
// ----------------------------------------------------------------------------
// Speed loop input channel
// One control tick request: setpoints, measurements and run flag.
// ----------------------------------------------------------------------------
interface dds_in_if;
	logic               valid;
	logic               ready;
	logic signed [9:0]  cruise_speed;
	logic signed [9:0]  rate_target;
	logic signed [12:0] rate_measured;
	logic signed [10:0] speed_left;
	logic signed [10:0] speed_right;
	logic               run_enable;

	modport source (
		output valid, cruise_speed, rate_target, rate_measured,
		output speed_left, speed_right, run_enable,
		input  ready
	);

	modport sink (
		input  valid, cruise_speed, rate_target, rate_measured,
		input  speed_left, speed_right, run_enable,
		output ready
	);
endinterface

FILE: rtl/core/dds_out_if.sv
// ----------------------------------------------------------------------------
// Speed loop output channel
// One result request per tick: two PWM commands and the planned speed.
// ----------------------------------------------------------------------------
interface dds_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pwm_left;
	logic signed [15:0] pwm_right;
	logic signed [9:0]  ramped_speed;

	modport source (
		output valid, pwm_left, pwm_right, ramped_speed,
		input  ready
	);

	modport sink (
		input  valid, pwm_left, pwm_right, ramped_speed,
		output ready
	);
endinterface

FILE: rtl/core/differential_drive_speed_loop.sv
// One request at a time: a new request is taken only once the last result is in the output register.
// All requests share one 17x17 multiplier that forms eight products per tick
// (two for the rate PD, three per wheel PI), each followed by its accumulate step.
// A finished result waits in the output register while the next request is taken.
// Reset clears the controller, the ramp, all PD/PI state and restores register defaults.
// ----------------------------------------------------------------------------
// Differential drive speed loop
// Rate PD, speed ramp and two incremental PI wheel loops with feedforward.
// ----------------------------------------------------------------------------
`include "differential_drive_speed_loop_assert.svh"

module differential_drive_speed_loop
	import dds_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	dds_in_if.sink                in_ch,
	dds_out_if.source             out_ch,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dds_cfg_t cfg_q;
	dds_cmd_t cmd;
	dds_sts_t sts;
	logic     in_ready;
	logic     in_accept;
	logic     pwm_in_range;

	logic signed [15:0] lim16, neg_lim16;

	// register writes; unknown index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_kp   <= 16'd307;
			cfg_q.rate_kd   <= 16'd26;
			cfg_q.wheel_kp  <= 16'd4608;
			cfg_q.wheel_ki  <= 16'd384;
			cfg_q.wheel_kff <= 16'd3840;
			cfg_q.ramp_step <= 8'd3;
			cfg_q.pwm_limit <= 15'd9500;
		end else if (cfg_wr_en) begin
			unique case (dds_cfg_idx_t'(cfg_index))
				CFG_RATE_KP:   cfg_q.rate_kp   <= cfg_data;
				CFG_RATE_KD:   cfg_q.rate_kd   <= cfg_data;
				CFG_WHEEL_KP:  cfg_q.wheel_kp  <= cfg_data;
				CFG_WHEEL_KI:  cfg_q.wheel_ki  <= cfg_data;
				CFG_WHEEL_KFF: cfg_q.wheel_kff <= cfg_data;
				CFG_RAMP_STEP: cfg_q.ramp_step <= cfg_data[7:0];
				CFG_PWM_LIMIT: cfg_q.pwm_limit <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	dds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dds_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg           (cfg_q),
		.cruise_speed  (in_ch.cruise_speed),
		.rate_target   (in_ch.rate_target),
		.rate_measured (in_ch.rate_measured),
		.speed_left    (in_ch.speed_left),
		.speed_right   (in_ch.speed_right),
		.run_enable    (in_ch.run_enable),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.pwm_left      (out_ch.pwm_left),
		.pwm_right     (out_ch.pwm_right),
		.ramped_speed  (out_ch.ramped_speed)
	);

	assign in_ch.ready = in_ready;

	assign lim16     = signed'({1'b0, cfg_q.pwm_limit});
	assign neg_lim16 = -lim16;

	assign in_accept    = in_ch.valid & in_ready;
	assign pwm_in_range = (out_ch.pwm_left <= lim16) && (out_ch.pwm_left >= neg_lim16)
		&& (out_ch.pwm_right <= lim16) && (out_ch.pwm_right >= neg_lim16);

	`DDS_ASSERT_NEXT(a_one_request_in_flight, clk, arst_n, in_accept, !in_ready, "request mid-tick")
	`DDS_ASSERT_IMPL(a_pwm_within_limit, clk, arst_n, out_ch.valid, pwm_in_range, "PWM over limit")

endmodule

FILE: rtl/core/dds_ctrl.sv
// ----------------------------------------------------------------------------
// Speed loop controller
// Sequences the rate PD and both wheel PI loops over the shared multiplier.
// ----------------------------------------------------------------------------
module dds_ctrl
	import dds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dds_sts_t sts,
	output dds_cmd_t cmd
);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_RATE   = 15'b000000000000010,
		ST_RKP    = 15'b000000000000100,
		ST_RKD    = 15'b000000000001000,
		ST_RSUM   = 15'b000000000010000,
		ST_DIFF   = 15'b000000000100000,
		ST_WERR   = 15'b000000001000000,
		ST_WKP    = 15'b000000010000000,
		ST_WKI    = 15'b000000100000000,
		ST_WSUM   = 15'b000001000000000,
		ST_WCLAMP = 15'b000010000000000,
		ST_WFF    = 15'b000100000000000,
		ST_WTOT   = 15'b001000000000000,
		ST_WPWM   = 15'b010000000000000,
		ST_DONE   = 15'b100000000000000
	} dds_state_t;

	dds_state_t state_q, state_d;
	logic       side_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.side     = side_q;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_RATE;
				end
			end
			ST_RATE: begin
				cmd.rate_step = 1'b1;
				state_d       = ST_RKP;
			end
			ST_RKP: begin
				cmd.mul_sel = MUL_RATE_KP;
				state_d     = ST_RKD;
			end
			ST_RKD: begin
				cmd.mul_sel = MUL_RATE_KD;
				cmd.acc_op  = ACC_LOAD;
				state_d     = ST_RSUM;
			end
			ST_RSUM: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff_load = 1'b1;
				state_d       = ST_WERR;
			end
			ST_WERR: begin
				cmd.wheel_err = 1'b1;
				state_d       = ST_WKP;
			end
			ST_WKP: begin
				cmd.mul_sel = MUL_WHEEL_KP;
				state_d     = ST_WKI;
			end
			ST_WKI: begin
				// old accumulator plus the proportional increment
				cmd.mul_sel = MUL_WHEEL_KI;
				cmd.acc_op  = ACC_ACCUM;
				state_d     = ST_WSUM;
			end
			ST_WSUM: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_WCLAMP;
			end
			ST_WCLAMP: begin
				cmd.accum_load = 1'b1;
				state_d        = ST_WFF;
			end
			ST_WFF: begin
				cmd.mul_sel = MUL_WHEEL_FF;
				state_d     = ST_WTOT;
			end
			ST_WTOT: begin
				cmd.acc_op = ACC_ACCUM;
				state_d    = ST_WPWM;
			end
			ST_WPWM: begin
				cmd.pwm_load = 1'b1;
				state_d      = side_q ? ST_DONE : ST_WERR;
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture)
				side_q <= 1'b0;
			else if (cmd.pwm_load)
				side_q <= ~side_q;
		end
	end

endmodule

FILE: rtl/core/dds_datapath.sv
// ----------------------------------------------------------------------------
// Speed loop datapath
// Shared 17x17 multiplier, accumulator, clamps and loop state registers.
// ----------------------------------------------------------------------------
module dds_datapath
	import dds_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dds_cmd_t           cmd,
	output dds_sts_t           sts,
	input  dds_cfg_t           cfg,
	input  logic signed [9:0]  cruise_speed,
	input  logic signed [9:0]  rate_target,
	input  logic signed [12:0] rate_measured,
	input  logic signed [10:0] speed_left,
	input  logic signed [10:0] speed_right,
	input  logic               run_enable,
	input  logic               out_ready,
	output logic               out_valid,
	output logic signed [15:0] pwm_left,
	output logic signed [15:0] pwm_right,
	output logic signed [9:0]  ramped_speed
);

	// captured request
	logic signed [9:0]  base_q, rt_q;
	logic signed [12:0] rm_q;
	logic signed [10:0] sl_q, sr_q;
	logic               run_q;

	// loop state
	logic signed [SPEED_W-1:0] ramp_q;
	logic signed [RERR_W-1:0]  rate_prev_q;
	logic signed [ACCUM_W-1:0] accum_l_q, accum_r_q;
	logic signed [TGT_W-1:0]   prev_l_q, prev_r_q;

	// working registers
	logic signed [RERR_W-1:0]  e_q;
	logic signed [RERR_W:0]    de_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [TGT_W-1:0]   err_q;
	logic signed [TGT_W:0]     derr_q;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PWM_W-1:0]   pwm_l_q, pwm_r_q;

	logic               out_valid_q;
	logic signed [15:0] out_pwm_l_q, out_pwm_r_q;
	logic signed [9:0]  out_ramp_q;

	logic signed [RERR_W-1:0]  rate_err;
	logic signed [RERR_W:0]    rate_de;
	logic signed [11:0]        base_x, step_x, ramp_x;
	logic signed [SPEED_W-1:0] ramp_next;
	logic signed [ACC_W-1:0]   rnd, rnd_sh;
	logic signed [DIFF_W-1:0]  diff_sat;
	logic signed [TGT_W-1:0]   tgt, meas, wheel_err;
	logic signed [TGT_W-1:0]   prev_sel;
	logic signed [TGT_W:0]     wheel_derr;
	logic signed [ACCUM_W-1:0] accum_sel;
	logic [15:0]               gain;
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod_c;
	logic signed [ACC_W-1:0]   lim, neg_lim;
	logic signed [ACCUM_W-1:0] acc_clamped, trunc_sum;
	logic signed [PWM_W-1:0]   pwm_val;

	// rate error and its change
	assign rate_err = RERR_W'(rt_q) - RERR_W'(rm_q);
	assign rate_de  = (RERR_W+1)'(rate_err) - (RERR_W+1)'(rate_prev_q);

	// ramp toward base speed, at most one step per tick
	assign base_x = 12'(base_q);
	assign ramp_x = 12'(ramp_q);
	assign step_x = signed'({4'b0000, cfg.ramp_step});

	always_comb begin
		if (ramp_x < base_x - step_x)
			ramp_next = SPEED_W'(ramp_x + step_x);
		else if (ramp_x > base_x + step_x)
			ramp_next = SPEED_W'(ramp_x - step_x);
		else
			ramp_next = base_q;
	end

	// round half up to integer, then saturate the speed difference
	assign rnd    = acc_q + ACC_W'(128);
	assign rnd_sh = rnd >>> 8;

	always_comb begin
		if (rnd_sh > ACC_W'(16383))
			diff_sat = DIFF_W'(16383);
		else if (rnd_sh < -ACC_W'(16383))
			diff_sat = -DIFF_W'(16383);
		else
			diff_sat = DIFF_W'(rnd_sh);
	end

	// wheel targets: left is planned minus difference, right planned plus
	assign tgt        = cmd.side ? (TGT_W'(ramp_q) + TGT_W'(diff_q))
	                             : (TGT_W'(ramp_q) - TGT_W'(diff_q));
	assign meas       = cmd.side ? TGT_W'(sr_q) : TGT_W'(sl_q);
	assign wheel_err  = tgt - meas;
	assign prev_sel   = cmd.side ? prev_r_q : prev_l_q;
	assign wheel_derr = (TGT_W+1)'(wheel_err) - (TGT_W+1)'(prev_sel);
	assign accum_sel  = cmd.side ? accum_r_q : accum_l_q;

	// shared multiplier: unsigned gain times signed operand
	always_comb begin
		case (cmd.mul_sel)
			MUL_RATE_KP: begin
				gain  = cfg.rate_kp;
				mul_b = MUL_W'(e_q);
			end
			MUL_RATE_KD: begin
				gain  = cfg.rate_kd;
				mul_b = MUL_W'(de_q);
			end
			MUL_WHEEL_KP: begin
				gain  = cfg.wheel_kp;
				mul_b = derr_q;
			end
			MUL_WHEEL_KI: begin
				gain  = cfg.wheel_ki;
				mul_b = MUL_W'(err_q);
			end
			MUL_WHEEL_FF: begin
				gain  = cfg.wheel_kff;
				mul_b = MUL_W'(tgt);
			end
			default: begin
				gain  = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_a  = signed'({1'b0, gain});
	assign prod_c = mul_a * mul_b;

	// symmetric clamp at pwm_limit in Q8
	assign lim     = signed'({12'd0, cfg.pwm_limit, 8'd0});
	assign neg_lim = -lim;

	always_comb begin
		if (acc_q > lim)
			acc_clamped = ACCUM_W'(lim);
		else if (acc_q < neg_lim)
			acc_clamped = ACCUM_W'(neg_lim);
		else
			acc_clamped = ACCUM_W'(acc_q);
	end

	// drop the fraction, truncating toward zero
	assign trunc_sum = acc_clamped + (acc_clamped[ACCUM_W-1] ? ACCUM_W'(255) : ACCUM_W'(0));
	assign pwm_val   = PWM_W'(trunc_sum >>> 8);

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		if (cmd.capture) begin
			base_q <= cruise_speed;
			rt_q   <= rate_target;
			rm_q   <= rate_measured;
			sl_q   <= speed_left;
			sr_q   <= speed_right;
			run_q  <= run_enable;
		end
		if (cmd.rate_step) begin
			e_q  <= rate_err;
			de_q <= rate_de;
		end
		if (cmd.diff_load)
			diff_q <= diff_sat;
		if (cmd.wheel_err) begin
			err_q  <= wheel_err;
			derr_q <= wheel_derr;
		end
		case (cmd.acc_op)
			ACC_LOAD:  acc_q <= ACC_W'(prod_s1);
			ACC_ADD:   acc_q <= acc_q + ACC_W'(prod_s1);
			ACC_ACCUM: acc_q <= ACC_W'(accum_sel) + ACC_W'(prod_s1);
			default:   acc_q <= acc_q;
		endcase
		if (cmd.pwm_load) begin
			if (cmd.side)
				pwm_r_q <= pwm_val;
			else
				pwm_l_q <= pwm_val;
		end
		if (cmd.out_load) begin
			out_pwm_l_q <= run_q ? pwm_l_q : '0;
			out_pwm_r_q <= run_q ? pwm_r_q : '0;
			out_ramp_q  <= ramp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q      <= '0;
			rate_prev_q <= '0;
			accum_l_q   <= '0;
			accum_r_q   <= '0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rate_step) begin
				rate_prev_q <= rate_err;
				ramp_q      <= ramp_next;
			end
			if (cmd.wheel_err) begin
				if (cmd.side)
					prev_r_q <= wheel_err;
				else
					prev_l_q <= wheel_err;
			end
			if (cmd.accum_load) begin
				if (cmd.side)
					accum_r_q <= acc_clamped;
				else
					accum_l_q <= acc_clamped;
			end
			out_valid_q <= cmd.out_load | (out_valid_q & ~out_ready);
		end
	end

	assign sts.out_free = ~out_valid_q | out_ready;
	assign out_valid    = out_valid_q;
	assign pwm_left     = out_pwm_l_q;
	assign pwm_right    = out_pwm_r_q;
	assign ramped_speed = out_ramp_q;

endmodule

FILE: test/differential_drive_speed_loop_tb.sv
// ----------------------------------------------------------------------------
// Differential drive speed loop testbench
// Sends control ticks through the request channel with random gaps and
// back-pressure. A bit-accurate model of the rate PD, the speed ramp and both
// incremental PI wheel loops predicts every result. Gains are changed between
// phases while the loop is idle, zero and full-scale settings included.
// ----------------------------------------------------------------------------
module differential_drive_speed_loop_tb;
	import dds_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
	localparam longint DIFF_LIMIT  = 16383;
	localparam int     QUIET_LIMIT = 2000;

	typedef struct {
		logic signed [9:0]  cruise_speed;
		logic signed [9:0]  rate_target;
		logic signed [12:0] rate_measured;
		logic signed [10:0] speed_left;
		logic signed [10:0] speed_right;
		logic               run_enable;
	} tick_t;

	typedef struct {
		logic signed [PWM_W-1:0]   pwm_left;
		logic signed [PWM_W-1:0]   pwm_right;
		logic signed [SPEED_W-1:0] ramped_speed;
	} drive_cmd_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dds_in_if  in_ch();
	dds_out_if out_ch();

	differential_drive_speed_loop u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model of the register file and of the loop state
	dds_cfg_t gains;
	longint   ramp_state;
	longint   rate_err_prev;
	longint   accum_left;
	longint   accum_right;
	longint   err_prev_left;
	longint   err_prev_right;

	tick_t      tick_q[$];
	drive_cmd_t drive_cmd_q[$];
	tick_t      on_wire;
	int         ticks_issued;
	int         cmds_seen;
	int         failures;
	int         quiet_cycles;
	int         drift_base;
	bit         steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint wheel_pwm(input longint target, input longint measured,
			inout longint accum, inout longint err_prev);
		longint lim, kp, ki, kff, err, total;
		lim = gains.pwm_limit;
		lim = lim * 256;
		kp = gains.wheel_kp;
		ki = gains.wheel_ki;
		kff = gains.wheel_kff;
		err = target - measured;
		accum = clamp_sym(accum + kp * (err - err_prev) + ki * err, lim);
		err_prev = err;
		total = clamp_sym(kff * target + accum, lim);
		// signed division truncates toward zero
		return total / 256;
	endfunction

	function automatic drive_cmd_t next_drive_cmd(input tick_t t);
		longint kp, kd, step, base, e, de, pd, diff, pl, pr;
		drive_cmd_t c;
		kp = gains.rate_kp;
		kd = gains.rate_kd;
		step = gains.ramp_step;
		base = t.cruise_speed;
		e = t.rate_target;
		e = e - t.rate_measured;
		de = e - rate_err_prev;
		rate_err_prev = e;
		// round half up: floor((x + 128) / 256)
		pd = (kp * e + kd * de + 128) >>> 8;
		diff = clamp_sym(pd, DIFF_LIMIT);
		if (ramp_state < base - step)
			ramp_state = ramp_state + step;
		else if (ramp_state > base + step)
			ramp_state = ramp_state - step;
		else
			ramp_state = base;
		pl = wheel_pwm(ramp_state - diff, t.speed_left, accum_left, err_prev_left);
		pr = wheel_pwm(ramp_state + diff, t.speed_right, accum_right, err_prev_right);
		c.pwm_left = t.run_enable ? pl[PWM_W-1:0] : '0;
		c.pwm_right = t.run_enable ? pr[PWM_W-1:0] : '0;
		c.ramped_speed = ramp_state[SPEED_W-1:0];
		return c;
	endfunction

	function automatic tick_t make_tick(input int b, input int rt, input int rm,
			input int sl, input int sr, input bit run);
		tick_t t;
		t.cruise_speed = 10'(b);
		t.rate_target = 10'(rt);
		t.rate_measured = 13'(rm);
		t.speed_left = 11'(sl);
		t.speed_right = 11'(sr);
		t.run_enable = run;
		return t;
	endfunction

	function automatic int pick(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// mostly a smooth drive: base wanders, wheels track it, small rate errors
	function automatic tick_t random_tick();
		tick_t t;
		int rt;
		if ($urandom_range(99) < 25) begin
			t.cruise_speed = 10'($urandom);
			t.rate_target = 10'($urandom);
			t.rate_measured = 13'($urandom);
			t.speed_left = 11'($urandom);
			t.speed_right = 11'($urandom);
			t.run_enable = 1'($urandom);
		end else begin
			drift_base = drift_base + pick(-20, 20);
			if (drift_base > 450)
				drift_base = 450;
			if (drift_base < -450)
				drift_base = -450;
			rt = pick(-150, 150);
			t = make_tick(drift_base, rt, rt + pick(-60, 60),
				drift_base + pick(-80, 80), drift_base + pick(-80, 80),
				$urandom_range(99) < 95);
		end
		return t;
	endfunction

	task automatic queue_tick(input tick_t t);
		tick_q.push_back(t);
		ticks_issued++;
	endtask

	task automatic wait_drained();
		while (cmds_seen < ticks_issued)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_RATE_KP:   gains.rate_kp = data;
			CFG_RATE_KD:   gains.rate_kd = data;
			CFG_WHEEL_KP:  gains.wheel_kp = data;
			CFG_WHEEL_KI:  gains.wheel_ki = data;
			CFG_WHEEL_KFF: gains.wheel_kff = data;
			CFG_RAMP_STEP: gains.ramp_step = data[7:0];
			CFG_PWM_LIMIT: gains.pwm_limit = data[14:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic write_all(input logic [15:0] rkp, input logic [15:0] rkd,
			input logic [15:0] wkp, input logic [15:0] wki, input logic [15:0] kff,
			input logic [15:0] step, input logic [15:0] lim);
		write_reg(CFG_RATE_KP, rkp);
		write_reg(CFG_RATE_KD, rkd);
		write_reg(CFG_WHEEL_KP, wkp);
		write_reg(CFG_WHEEL_KI, wki);
		write_reg(CFG_WHEEL_KFF, kff);
		write_reg(CFG_RAMP_STEP, step);
		write_reg(CFG_PWM_LIMIT, lim);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				drive_cmd_q.push_back(next_drive_cmd(on_wire));
			if (!in_ch.valid || in_ch.ready) begin
				if (tick_q.size() != 0 && (steady || $urandom_range(99) >= 22)) begin
					on_wire = tick_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.cruise_speed <= on_wire.cruise_speed;
					in_ch.rate_target <= on_wire.rate_target;
					in_ch.rate_measured <= on_wire.rate_measured;
					in_ch.speed_left <= on_wire.speed_left;
					in_ch.speed_right <= on_wire.speed_right;
					in_ch.run_enable <= on_wire.run_enable;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : result_check
		drive_cmd_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= steady || $urandom_range(99) >= 22;
			if (out_ch.valid && out_ch.ready) begin
				cmds_seen++;
				if (drive_cmd_q.size() == 0) begin
					$error("result with no request pending");
					failures++;
				end else begin
					want = drive_cmd_q.pop_front();
					if (out_ch.pwm_left !== want.pwm_left) begin
						$error("pwm_left: expected %0d, got %0d",
							want.pwm_left, out_ch.pwm_left);
						failures++;
					end
					if (out_ch.pwm_right !== want.pwm_right) begin
						$error("pwm_right: expected %0d, got %0d",
							want.pwm_right, out_ch.pwm_right);
						failures++;
					end
					if (out_ch.ramped_speed !== want.ramped_speed) begin
						$error("ramped_speed: expected %0d, got %0d",
							want.ramped_speed, out_ch.ramped_speed);
						failures++;
					end
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cruise_speed = '0;
		in_ch.rate_target = '0;
		in_ch.rate_measured = '0;
		in_ch.speed_left = '0;
		in_ch.speed_right = '0;
		in_ch.run_enable = 1'b0;
		out_ch.ready = 1'b0;
		quiet_cycles = 0;
		failures = 0;
		ticks_issued = 0;
		cmds_seen = 0;
		drift_base = 0;
		steady = 1'b0;
		gains.rate_kp = 16'd307;
		gains.rate_kd = 16'd26;
		gains.wheel_kp = 16'd4608;
		gains.wheel_ki = 16'd384;
		gains.wheel_kff = 16'd3840;
		gains.ramp_step = 8'd3;
		gains.pwm_limit = 15'd9500;
		ramp_state = 0;
		rate_err_prev = 0;
		accum_left = 0;
		accum_right = 0;
		err_prev_left = 0;
		err_prev_right = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset gains: field extremes, run off, ramp settling onto its target
		queue_tick(make_tick(0, 0, 0, 0, 0, 1'b1));
		queue_tick(make_tick(511, 511, -4096, -1024, 1023, 1'b1));
		queue_tick(make_tick(-512, -512, 4095, 1023, -1024, 1'b1));
		queue_tick(make_tick(511, 511, -4096, -1024, 1023, 1'b0));
		queue_tick(make_tick(511, 511, 4095, 1023, 1023, 1'b1));
		queue_tick(make_tick(-512, -512, -4096, -1024, -1024, 1'b1));
		queue_tick(make_tick(-1, -1, -1, -1, -1, 1'b0));
		repeat (4) queue_tick(make_tick(10, 20, 5, 8, 12, 1'b1));
		repeat (3) queue_tick(make_tick(-4, -30, 10, -6, -2, 1'b1));
		queue_tick(make_tick(0, 0, 0, 0, 0, 1'b0));
		queue_tick(make_tick(100, 50, 50, 100, 100, 1'b1));
		wait_drained();

		// unknown index: must leave every gain alone
		write_reg(CFG_UNUSED_IDX, 16'hFFFF);
		repeat (60) queue_tick(random_tick());
		wait_drained();

		// full scale; upper bits of ramp step and limit are dropped
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_tick(make_tick(511, 511, -4096, -1024, 1023, 1'b1));
		queue_tick(make_tick(-512, -512, 4095, 1023, -1024, 1'b1));
		queue_tick(make_tick(511, -512, 4095, -1024, -1024, 1'b1));
		repeat (40) queue_tick(random_tick());
		wait_drained();

		// all zero: ramp holds until it meets base, zero limit pins the outputs
		write_all('0, '0, '0, '0, '0, '0, '0);
		queue_tick(make_tick(int'(ramp_state > 0 ? ramp_state - 7 : ramp_state + 7),
			100, -300, 50, -50, 1'b1));
		queue_tick(make_tick(int'(ramp_state), 0, 0, 0, 0, 1'b1));
		repeat (30) queue_tick(random_tick());
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			if (p % 2 == 0)
				write_all(16'($urandom_range(1000)), 16'($urandom_range(200)),
					16'($urandom_range(8000)), 16'($urandom_range(1000)),
					16'($urandom_range(6000)), 16'($urandom_range(1, 20)),
					16'($urandom_range(500, 20000)));
			else
				write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom));
			steady = (p == 3);
			repeat (70) queue_tick(random_tick());
			wait_drained();
		end
		steady = 1'b0;

		write_all(16'd307, 16'd26, 16'd4608, 16'd384, 16'd3840, 16'd3, 16'd9500);
		repeat (60) queue_tick(random_tick());
		wait_drained();

		// catch any stray result after the last one, and any result that never arrived
		repeat (40) @(posedge clk);
		if (drive_cmd_q.size() != 0) begin
			$error("%0d results never arrived", drive_cmd_q.size());
			failures++;
		end
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
